[sv/vsc_pkg.sv]
`timescale 1ns / 1ps
package vsc_pkg;

  localparam logic [1:0] REQ_APPEND_A = 2'd0;
  localparam logic [1:0] REQ_APPEND_B = 2'd1;
  localparam logic [1:0] REQ_COMPARE  = 2'd2;

  localparam logic [1:0] ORD_BEFORE = 2'd0;
  localparam logic [1:0] ORD_EQUAL  = 2'd1;
  localparam logic [1:0] ORD_AFTER  = 2'd2;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [0:0] CFG_IDX_CHECK_PRE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // compare requested: reset walk pointers
    logic seg_step;   // advance core segment parse by one byte
    logic pre_init;   // locate pre-release parts
    logic pre_step;   // advance pre-release scan or compare a byte pair
    logic clear;      // clear lengths and flag
  } vsc_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic seg_done;   // core walk finished (equal so far)
    logic seg_diff;   // core decided
    logic pre_done;   // pre-release walk decided or finished
    logic [1:0] order;
  } vsc_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[sv/vsc_ctrl.sv]
`timescale 1ns / 1ps
module vsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire_cmp,
  input  logic                check_pre,
  input  logic                out_free,
  input  vsc_pkg::vsc_sts_t   sts,
  output vsc_pkg::vsc_cmd_t   cmd,
  output logic                busy,
  output logic                res_valid,
  output logic [1:0]          res_order
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEG  = 5'b00010,
    ST_PREI = 5'b00100,
    ST_PRE  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ord_r, ord_nxt;

  always_comb begin
    state_nxt = state_r;
    ord_nxt   = ord_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire_cmp) begin
          cmd.start = 1'b1;
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        if (sts.seg_diff) begin
          ord_nxt   = sts.order;
          state_nxt = ST_DONE;
        end else if (sts.seg_done) begin
          ord_nxt   = vsc_pkg::ORD_EQUAL;
          state_nxt = check_pre ? ST_PREI : ST_DONE;
        end else begin
          cmd.seg_step = 1'b1;
        end
      end
      ST_PREI: begin
        cmd.pre_init = 1'b1;
        state_nxt    = ST_PRE;
      end
      ST_PRE: begin
        if (sts.pre_done) begin
          ord_nxt   = sts.order;
          state_nxt = ST_DONE;
        end else begin
          cmd.pre_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ord_r   <= vsc_pkg::ORD_EQUAL;
    end else begin
      state_r <= state_nxt;
      ord_r   <= ord_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE) && out_free;
  assign res_order = ord_r;

endmodule

[sv/vsc_dp.sv]
`timescale 1ns / 1ps
module vsc_dp #(
  parameter int MAX_LEN   = 64,
  parameter int SEG_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              app_a,
  input  logic              app_b,
  input  logic [7:0]        char_code,
  input  vsc_pkg::vsc_cmd_t cmd,
  output vsc_pkg::vsc_sts_t sts,
  output logic              trunc
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] FULL = LW'(MAX_LEN);
  localparam logic [SEG_WIDTH-1:0] TOP = '1;

  logic [7:0] mem_a [MAX_LEN];
  logic [7:0] mem_b [MAX_LEN];
  logic [7:0] rd_a_r, rd_b_r;
  logic [AW-1:0] rda, rdb;
  logic [LW-1:0] len_a_r, len_b_r;
  logic          trunc_r;

  // Walk state per side: position, segment value, flags.
  logic [LW-1:0]        pa_r, pb_r, pa_nxt, pb_nxt;
  logic                 fa_r, fb_r;        // core end found
  logic [SEG_WIDTH-1:0] va_r, vb_r;
  logic                 ina_r, inb_r;      // inside a digit run
  logic                 sa_r, sb_r;        // segment ready
  // Pre-release walk
  logic [LW-1:0]        qa_r, qb_r, qa_nxt, qb_nxt;
  logic                 ha_r, hb_r, da_r, db_r; // have pre / found boundary
  logic                 mode_r;            // 0 scan, 1 compare

  // The read registers always hold the byte at the current walk pointer:
  // the memories are addressed with the pointer's next value.
  logic [7:0] ca, cb;
  assign ca = rd_a_r;
  assign cb = rd_b_r;

  always_ff @(posedge clk) begin
    if (app_a && len_a_r != FULL) mem_a[len_a_r[AW-1:0]] <= char_code;
    if (app_b && len_b_r != FULL) mem_b[len_b_r[AW-1:0]] <= char_code;
    rd_a_r <= mem_a[rda];
    rd_b_r <= mem_b[rdb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= '0;
      len_b_r <= '0;
      trunc_r <= 1'b0;
    end else if (cmd.clear) begin
      len_a_r <= '0;
      len_b_r <= '0;
      trunc_r <= 1'b0;
    end else begin
      if (app_a) begin
        if (len_a_r != FULL) len_a_r <= len_a_r + LW'(1);
        else trunc_r <= 1'b1;
      end
      if (app_b) begin
        if (len_b_r != FULL) len_b_r <= len_b_r + LW'(1);
        else trunc_r <= 1'b1;
      end
    end
  end
  assign trunc = trunc_r;

  // Saturating decimal accumulate.
  function automatic logic [SEG_WIDTH-1:0] acc(input logic [SEG_WIDTH-1:0] v,
                                               input logic [7:0] c);
    logic [SEG_WIDTH+3:0] t;
    t = {4'd0, v} * (SEG_WIDTH+4)'(10) + (SEG_WIDTH+4)'(c - vsc_pkg::CH_ZERO);
    return (t > {4'd0, TOP}) ? TOP : t[SEG_WIDTH-1:0];
  endfunction

  // Segment walk: each side advances one byte per cycle until it holds a
  // finished segment (or reached its core end). When both are ready the
  // segments are compared and the walk restarts.
  logic a_end, b_end, a_dig, b_dig, a_rdy, b_rdy;
  always_comb begin
    a_end = (pa_r == len_a_r) || fa_r ||
            ca == vsc_pkg::CH_DASH || ca == vsc_pkg::CH_PLUS;
    b_end = (pb_r == len_b_r) || fb_r ||
            cb == vsc_pkg::CH_DASH || cb == vsc_pkg::CH_PLUS;
    a_dig = !a_end && vsc_pkg::is_digit(ca);
    b_dig = !b_end && vsc_pkg::is_digit(cb);
    a_rdy = sa_r || a_end || (ina_r && !a_dig);
    b_rdy = sb_r || b_end || (inb_r && !b_dig);
  end

  // Pre-release byte pair
  logic [7:0] xa, xb;
  logic xa_end, xb_end;
  assign xa = rd_a_r;
  assign xb = rd_b_r;
  assign xa_end = (qa_r == len_a_r) || xa == vsc_pkg::CH_PLUS;
  assign xb_end = (qb_r == len_b_r) || xb == vsc_pkg::CH_PLUS;

  // Next walk pointers, which also address the memories.
  always_comb begin
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    if (cmd.start) begin
      pa_nxt = '0;
      pb_nxt = '0;
    end else if (cmd.seg_step && !(a_rdy && b_rdy)) begin
      if (!a_rdy) pa_nxt = pa_r + LW'(1);
      if (!b_rdy) pb_nxt = pb_r + LW'(1);
    end
    qa_nxt = qa_r;
    qb_nxt = qb_r;
    if (cmd.pre_init) begin
      qa_nxt = '0;
      qb_nxt = '0;
    end else if (cmd.pre_step) begin
      if (mode_r) begin
        qa_nxt = qa_r + LW'(1);
        qb_nxt = qb_r + LW'(1);
      end else begin
        if (!da_r && !xa_end) qa_nxt = qa_r + LW'(1);
        if (!db_r && !xb_end) qb_nxt = qb_r + LW'(1);
      end
    end
    rda = (cmd.pre_init || cmd.pre_step) ? qa_nxt[AW-1:0] : pa_nxt[AW-1:0];
    rdb = (cmd.pre_init || cmd.pre_step) ? qb_nxt[AW-1:0] : pb_nxt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    qa_r <= qa_nxt;
    qb_r <= qb_nxt;
    if (cmd.start) begin
      fa_r <= 1'b0; fb_r <= 1'b0;
      va_r <= '0; vb_r <= '0; ina_r <= 1'b0; inb_r <= 1'b0;
      sa_r <= 1'b0; sb_r <= 1'b0;
    end else if (cmd.seg_step) begin
      if (a_rdy && b_rdy) begin
        va_r <= '0; vb_r <= '0; ina_r <= 1'b0; inb_r <= 1'b0;
        sa_r <= 1'b0; sb_r <= 1'b0;
        fa_r <= a_end; fb_r <= b_end;
      end else begin
        if (!a_rdy) begin
          if (a_dig) begin
            va_r <= acc(va_r, ca);
            ina_r <= 1'b1;
          end
        end else begin
          sa_r <= 1'b1;
          fa_r <= a_end;
        end
        if (!b_rdy) begin
          if (b_dig) begin
            vb_r <= acc(vb_r, cb);
            inb_r <= 1'b1;
          end
        end else begin
          sb_r <= 1'b1;
          fb_r <= b_end;
        end
      end
    end
    if (cmd.start || cmd.pre_init) begin
      da_r <= 1'b0; db_r <= 1'b0;
      ha_r <= 1'b0; hb_r <= 1'b0; mode_r <= 1'b0;
    end else if (cmd.pre_step) begin
      if (!mode_r) begin
        // Find '-' before any '+' on each side.
        if (!da_r) begin
          if (xa_end) da_r <= 1'b1;
          else if (xa == vsc_pkg::CH_DASH) begin
            da_r <= 1'b1; ha_r <= 1'b1;
          end
        end
        if (!db_r) begin
          if (xb_end) db_r <= 1'b1;
          else if (xb == vsc_pkg::CH_DASH) begin
            db_r <= 1'b1; hb_r <= 1'b1;
          end
        end
        if (da_r && db_r) begin
          mode_r <= 1'b1;
          // Empty pre-release counts as a release.
          ha_r <= ha_r && !xa_end;
          hb_r <= hb_r && !xb_end;
        end
      end
    end
  end

  // Status
  always_comb begin
    sts = '0;
    sts.seg_diff = 1'b0;
    sts.seg_done = 1'b0;
    if (a_rdy && b_rdy) begin
      if (va_r != vb_r) begin
        sts.seg_diff = 1'b1;
        sts.order = (va_r < vb_r) ? vsc_pkg::ORD_BEFORE : vsc_pkg::ORD_AFTER;
      end else if (a_end && b_end) begin
        sts.seg_done = 1'b1;
      end
    end
    if (mode_r) begin
      sts.pre_done = 1'b1;
      if (!ha_r && !hb_r) sts.order = vsc_pkg::ORD_EQUAL;
      else if (!ha_r) sts.order = vsc_pkg::ORD_AFTER;
      else if (!hb_r) sts.order = vsc_pkg::ORD_BEFORE;
      else if (xa_end && xb_end) sts.order = vsc_pkg::ORD_EQUAL;
      else if (xa_end) sts.order = vsc_pkg::ORD_BEFORE;
      else if (xb_end) sts.order = vsc_pkg::ORD_AFTER;
      else if (xa != xb)
        sts.order = (xa < xb) ? vsc_pkg::ORD_BEFORE : vsc_pkg::ORD_AFTER;
      else sts.pre_done = 1'b0;
    end
  end

endmodule

[sv/version_string_compare.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Word contents
// in_      | slave     | tdata[7:0] char_code, tuser[1:0] req_type
// out_     | master    | tdata[1:0] order, tdata[2] overflow
// cfg_     | APB       | register 0 at address 0: check_prerelease
//
// Byte appends are accepted back to back while no compare is running.
// A compare walks the cores one byte per cycle per side, a side holding once
// its segment is finished, and compares each segment pair when both are ready;
// with check_prerelease set it then scans and compares the pre-release parts.
// Reset (rst_n, synchronous) empties both buffers and sets check_prerelease.
// The result waits in the output register while out_tready is low; no new
// word is accepted during a compare.
module version_string_compare #(
  parameter int MAX_LEN   = 64,
  parameter int SEG_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] order, [2] overflow, rest zero
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [0:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);

  logic check_pre_r;
  logic busy, res_valid, trunc, fire;
  logic [1:0] res_order;
  logic out_valid_r;
  logic [2:0] out_data_r;
  vsc_pkg::vsc_cmd_t cmd;
  vsc_pkg::vsc_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, check_pre_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_pre_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == vsc_pkg::CFG_IDX_CHECK_PRE) begin
      check_pre_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = !busy;
  assign fire = in_tvalid && in_tready;

  vsc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire_cmp (fire && in_tuser == vsc_pkg::REQ_COMPARE),
    .check_pre   (check_pre_r),
    .out_free    (!out_valid_r),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .res_valid   (res_valid),
    .res_order   (res_order)
  );

  vsc_dp #(.MAX_LEN(MAX_LEN), .SEG_WIDTH(SEG_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .app_a     (fire && in_tuser == vsc_pkg::REQ_APPEND_A),
    .app_b     (fire && in_tuser == vsc_pkg::REQ_APPEND_B),
    .char_code (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .trunc     (trunc)
  );

  // Output register holds the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data_r <= {trunc, res_order};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

endmodule
